/* hdl/clbs_pkg.sv */
// clbs_pkg: shared types, command codes and init sequence table for the
// character lcd bus sequencer. No dependencies.
`default_nettype none

package clbs_pkg;

   // request command codes
   localparam logic [2:0] CmdInit       = 3'd0;
   localparam logic [2:0] CmdWriteInstr = 3'd1;
   localparam logic [2:0] CmdWriteChar  = 3'd2;
   localparam logic [2:0] CmdClear      = 3'd3;
   localparam logic [2:0] CmdMoveCursor = 3'd4;

   // bus mode register values
   localparam logic ModeEightBit = 1'b0;
   localparam logic ModeFourBit  = 1'b1;

   // display instruction bytes
   localparam logic [7:0] InstFunc8     = 8'h38;
   localparam logic [7:0] InstDispOn    = 8'h0E;
   localparam logic [7:0] InstClear     = 8'h01;
   localparam logic [7:0] InstWake4a    = 8'h33;
   localparam logic [7:0] InstWake4b    = 8'h32;
   localparam logic [7:0] InstFunc4     = 8'h28;
   localparam logic [7:0] InstHome      = 8'h02;
   localparam logic [7:0] LineBaseTop   = 8'h80;
   localparam logic [7:0] LineBaseBot   = 8'hC0;
   localparam logic [7:0] NibbleHiMask  = 8'hF0;
   localparam logic [7:0] NibbleLoMask  = 8'h0F;

   // hold times in ms
   localparam logic [6:0] HoldNone      = 7'd0;
   localparam logic [6:0] HoldStrobe    = 7'd1;
   localparam logic [6:0] HoldSettle    = 7'd5;
   localparam logic [6:0] HoldPowerUp   = 7'd100;
   localparam logic [6:0] HoldInitMid   = 7'd20;

   // init runs through seven slots, each a wait or a byte transfer
   localparam logic [2:0] InitLastSlot  = 3'd6;

   // register index of bus_mode
   localparam logic RegBusMode = 1'b0;

   typedef struct packed {
      logic       is_wait;
      logic [7:0] data;
      logic [6:0] hold;
   } init_slot_type;

   typedef struct packed {
      logic       reg_select;
      logic       enable;
      logic [7:0] data_lines;
      logic [6:0] hold_ms;
      logic       last;
      logic       slot_end;
   } phase_type;

   // init slot table; a wait slot shows the byte sent just before it
   function automatic init_slot_type init_slot(input logic mode, input logic [2:0] slot);
      init_slot_type s;
      s = '{is_wait: 1'b0, data: 8'h00, hold: HoldNone};
      if (mode == ModeEightBit) begin
         case (slot)
            3'd0: s = '{is_wait: 1'b1, data: 8'h00, hold: HoldPowerUp};
            3'd1: s.data = InstFunc8;
            3'd2: s.data = InstDispOn;
            3'd3: s.data = InstClear;
            3'd4: s = '{is_wait: 1'b1, data: InstClear, hold: HoldInitMid};
            3'd5: s.data = InstFunc8;
            3'd6: s = '{is_wait: 1'b1, data: InstFunc8, hold: HoldSettle};
            default: s = '{is_wait: 1'b1, data: 8'h00, hold: HoldNone};
         endcase
      end else begin
         case (slot)
            3'd0: s = '{is_wait: 1'b1, data: 8'h00, hold: HoldPowerUp};
            3'd1: s.data = InstWake4a;
            3'd2: s.data = InstWake4b;
            3'd3: s.data = InstFunc4;
            3'd4: s.data = InstDispOn;
            3'd5: s.data = InstClear;
            3'd6: s.data = InstHome;
            default: s = '{is_wait: 1'b1, data: 8'h00, hold: HoldNone};
         endcase
      end
      return s;
   endfunction

endpackage

`default_nettype wire

/* hdl/char_lcd_bus_sequencer.sv */
// char_lcd_bus_sequencer: top level, request register, phase sequencer,
// result register and csr port. Depends on clbs_pkg and clbs_phase_gen.
`default_nettype none

// Turns each request into a run of lcd pin phases, one result item per clock
// cycle while the result side takes them. A request is a run of 3 phases
// (eight-bit) or 5 (four-bit) for write instruction, write character, clear
// and move cursor; 15 or 31 for init. The next request is taken in the cycle
// its predecessor's last phase is loaded into the result register, so runs
// follow each other with no gap; an unknown command is taken and gives no
// result. The bus_mode register is sampled when a request is taken.
module char_lcd_bus_sequencer (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [2:0]  req_command,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_row,
   input  wire logic [5:0]  req_column,
   // result channel
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_reg_select,
   output      logic        rsp_read_write,
   output      logic        rsp_enable,
   output      logic [7:0]  rsp_data_lines,
   output      logic [6:0]  rsp_hold_ms,
   output      logic        rsp_last,
   // csr port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);
   import clbs_pkg::*;

   logic       bus_mode_ff, bus_mode_in;
   logic       busy_ff, busy_in;
   logic       is_init_ff, is_init_in;
   logic       rs_ff, rs_in;
   logic       mode_ff, mode_in;
   logic [7:0] byte_ff, byte_in;
   logic [2:0] slot_ff, slot_in;
   logic [2:0] sub_ff, sub_in;

   logic       rsp_valid_ff, rsp_valid_in;
   phase_type  rsp_ff, rsp_in;

   phase_type  phase;
   logic       out_free;
   logic       issue;
   logic       accept;
   logic       cmd_known;
   logic       csr_write;
   logic [7:0] move_addr;

   // csr port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == RegBusMode) ? {31'b0, bus_mode_ff} : 32'b0;

   always_comb begin
      bus_mode_in = bus_mode_ff;
      if (csr_write && paddr[2] == RegBusMode) begin
         bus_mode_in = pwdata[0];
      end
   end

   // phase decode for the current slot
   clbs_phase_gen u_phase (
      .mode     (mode_ff),
      .is_init  (is_init_ff),
      .rs       (rs_ff),
      .byte_val (byte_ff),
      .slot     (slot_ff),
      .sub      (sub_ff),
      .phase    (phase)
   );

   // handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign issue     = busy_ff && out_free;
   assign req_ready = !busy_ff || (out_free && phase.last);
   assign accept    = req_valid && req_ready;
   assign cmd_known = (req_command <= CmdMoveCursor);
   assign move_addr = (req_row ? LineBaseBot : LineBaseTop) + {2'b00, req_column};

   // request register and slot / sub-phase counters
   always_comb begin
      busy_in    = busy_ff;
      is_init_in = is_init_ff;
      rs_in      = rs_ff;
      mode_in    = mode_ff;
      byte_in    = byte_ff;
      slot_in    = slot_ff;
      sub_in     = sub_ff;
      if (issue) begin
         if (phase.last) begin
            busy_in = 1'b0;
         end else if (phase.slot_end) begin
            slot_in = slot_ff + 3'd1;
            sub_in  = 3'd0;
         end else begin
            sub_in  = sub_ff + 3'd1;
         end
      end
      if (accept) begin
         busy_in    = cmd_known;
         is_init_in = (req_command == CmdInit);
         rs_in      = (req_command == CmdWriteChar);
         mode_in    = bus_mode_ff;
         slot_in    = 3'd0;
         sub_in     = 3'd0;
         case (req_command)
            CmdWriteInstr, CmdWriteChar: byte_in = req_byte_value;
            CmdClear:                    byte_in = InstClear;
            CmdMoveCursor:               byte_in = move_addr;
            default:                     byte_in = 8'h00;
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = issue;
         if (issue) begin
            rsp_in = phase;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_mode_ff  <= ModeEightBit;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= 3'd0;
         sub_ff       <= 3'd0;
      end else begin
         bus_mode_ff  <= bus_mode_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
         sub_ff       <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      is_init_ff <= is_init_in;
      rs_ff      <= rs_in;
      mode_ff    <= mode_in;
      byte_ff    <= byte_in;
      rsp_ff     <= rsp_in;
   end

   // outputs
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_select = rsp_ff.reg_select;
   assign rsp_read_write = 1'b0;
   assign rsp_enable     = rsp_ff.enable;
   assign rsp_data_lines = rsp_ff.data_lines;
   assign rsp_hold_ms    = rsp_ff.hold_ms;
   assign rsp_last       = rsp_ff.last;

endmodule

`default_nettype wire

/* hdl/clbs_phase_gen.sv */
// clbs_phase_gen: combinational pin-phase decoder for one slot and sub-phase.
// Depends on clbs_pkg.
`default_nettype none

module clbs_phase_gen (
   input  wire logic                 mode,
   input  wire logic                 is_init,
   input  wire logic                 rs,
   input  wire logic [7:0]           byte_val,
   input  wire logic [2:0]           slot,
   input  wire logic [2:0]           sub,
   output clbs_pkg::phase_type       phase
);
   import clbs_pkg::*;

   init_slot_type cur;
   logic [7:0]    hi_nib;
   logic [7:0]    lo_nib;

   // pick the slot: init table or the single request byte
   always_comb begin
      if (is_init) begin
         cur = init_slot(mode, slot);
      end else begin
         cur = '{is_wait: 1'b0, data: byte_val, hold: HoldNone};
      end
   end

   assign hi_nib = cur.data & NibbleHiMask;
   assign lo_nib = {cur.data[3:0], 4'h0};

   // sub-phase decode
   always_comb begin
      phase.reg_select = is_init ? 1'b0 : rs;
      phase.enable     = 1'b0;
      phase.data_lines = cur.data;
      phase.hold_ms    = HoldNone;
      phase.slot_end   = 1'b0;
      if (cur.is_wait) begin
         phase.reg_select = 1'b0;
         phase.hold_ms    = cur.hold;
         phase.slot_end   = 1'b1;
      end else if (mode == ModeEightBit) begin
         case (sub)
            3'd0: phase.hold_ms = HoldNone;
            3'd1: begin
               phase.enable  = 1'b1;
               phase.hold_ms = HoldStrobe;
            end
            default: begin
               phase.hold_ms  = HoldSettle;
               phase.slot_end = 1'b1;
            end
         endcase
      end else begin
         phase.data_lines = (sub < 3'd2) ? hi_nib : lo_nib;
         phase.enable     = sub[0];
         case (sub)
            3'd0, 3'd2: phase.hold_ms = HoldNone;
            3'd1, 3'd3: phase.hold_ms = HoldStrobe;
            default: begin
               phase.hold_ms  = HoldSettle;
               phase.slot_end = 1'b1;
            end
         endcase
      end
      phase.last = phase.slot_end && (!is_init || slot == InitLastSlot);
   end

endmodule

`default_nettype wire

/* hdl/clbs_checker.sv */
// clbs_checker: port-level assertions for char_lcd_bus_sequencer, bound to
// the top level below. No package dependency.
`default_nettype none

module clbs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_enable,
   input wire logic [7:0]  rsp_data_lines,
   input wire logic [6:0]  rsp_hold_ms,
   input wire logic        rsp_last
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_lines)
         && $stable(rsp_enable) && $stable(rsp_hold_ms) && $stable(rsp_last))
      else $error("stalled result item changed");

   // strobe-high phases hold for one ms and never end a run
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_enable |-> rsp_hold_ms == 7'd1 && !rsp_last)
      else $error("strobe phase malformed");

   // every run ends on a strobe-low phase with a nonzero hold
   a_last_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !rsp_enable && rsp_hold_ms != 7'd0)
      else $error("final phase malformed");

   // a strobe-high phase follows directly on a strobe-low set-up of the same data
   a_setup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 rsp_valid && rsp_enable
         |-> $past(!rsp_enable) && rsp_data_lines == $past(rsp_data_lines))
      else $error("strobe without set-up phase");

endmodule

bind char_lcd_bus_sequencer clbs_checker u_clbs_checker (.*);

`default_nettype wire
